/* rtl/fdem_pkg.sv */
// Shared types, codes and constants of the FAT directory entry matcher.
package fdem_pkg;

  // Layout of one 32-byte short-name directory entry.
  localparam int ENTRY_BYTES = 32;
  localparam int POS_W       = $clog2(ENTRY_BYTES);
  localparam int NAME_BYTES  = 11;
  localparam int BASE_BYTES  = 8;
  localparam int EXT_BYTES   = NAME_BYTES - BASE_BYTES;
  localparam int FORMED_MAX  = 12;

  // Byte offsets inside an entry.
  localparam logic [POS_W-1:0] POS_ATTR      = POS_W'(11);
  localparam logic [POS_W-1:0] POS_CLUS_HI_0 = POS_W'(20);
  localparam logic [POS_W-1:0] POS_CLUS_HI_1 = POS_W'(21);
  localparam logic [POS_W-1:0] POS_CLUS_LO_0 = POS_W'(26);
  localparam logic [POS_W-1:0] POS_CLUS_LO_1 = POS_W'(27);
  localparam logic [POS_W-1:0] POS_SIZE_0    = POS_W'(28);
  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(ENTRY_BYTES - 1);

  // Byte codes.
  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_DOT       = 8'h2E;
  localparam logic [7:0] MARK_DELETED   = 8'hE5;
  localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
  localparam logic [7:0] ATTR_VOLUME    = 8'h08;
  localparam logic [7:0] ATTR_DIRECTORY = 8'h10;

  // Depth of the queue between the capture and the decode side.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Entry kinds as reported on the result channel.
  typedef enum logic [2:0] {
    KIND_END       = 3'd0,
    KIND_DELETED   = 3'd1,
    KIND_LONG_NAME = 3'd2,
    KIND_VOLUME    = 3'd3,
    KIND_DIRECTORY = 3'd4,
    KIND_FILE      = 3'd5
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_FIRST_EIGHT = 2'd0,
    REG_LAST_FOUR   = 2'd1,
    REG_LENGTH      = 2'd2
  } reg_index_t;

  // One captured entry as it travels through the queue.
  typedef struct packed {
    logic [NAME_BYTES-1:0][7:0] name;
    logic [7:0]                 attr;
    logic [31:0]                cluster;
    logic [31:0]                size;
  } entry_rec_t;

  // Target name as configured.
  typedef struct packed {
    logic [FORMED_MAX-1:0][7:0] chars;
    logic [3:0]                 len;
  } target_t;

endpackage

/* rtl/fdem_in_if.sv */
// Input channel: one raw directory byte per item.
interface fdem_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       sector_start;

  modport source (output valid, data_byte, sector_start, input ready);
  modport sink (input valid, data_byte, sector_start, output ready);
endinterface

/* rtl/fdem_out_if.sv */
// Result channel: one decoded directory entry per item.
interface fdem_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  entry_kind;
  logic        name_matches;
  logic        name_blank;
  logic        empty_file;
  logic [31:0] first_cluster;
  logic [31:0] entry_size;
  logic [7:0]  attributes;

  modport source (output valid, entry_kind, name_matches, name_blank, empty_file,
                  first_cluster, entry_size, attributes, input ready);
  modport sink (input valid, entry_kind, name_matches, name_blank, empty_file,
                first_cluster, entry_size, attributes, output ready);
endinterface

/* rtl/fdem_front.sv */
// Capture side: tracks the byte position and gathers the fields of each entry.
module fdem_front
  import fdem_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  fdem_in_if.sink       in_ch,
  input  logic          queue_full,
  output logic          push,
  output entry_rec_t    push_rec
);

  logic [POS_W-1:0]           entry_position;
  logic [POS_W-1:0]           pos;
  logic                       accept;
  logic [NAME_BYTES-1:0][7:0] name_bytes;
  logic [7:0]                 attr_byte;
  logic [15:0]                cluster_high;
  logic [15:0]                cluster_low;
  logic [3:0][7:0]            size_bytes;

  // A new item is taken whenever the queue has room for a finished entry.
  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // A sector start restarts the entry at byte zero.
  assign pos = in_ch.sector_start ? '0 : entry_position;

  // Byte position, wrapping after the last byte of an entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_position <= '0;
    end else if (accept) begin
      entry_position <= pos + POS_W'(1);
    end
  end

  // Field capture; bytes at offsets that carry nothing of interest are dropped.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos < POS_W'(NAME_BYTES)) begin
        name_bytes[pos[3:0]] <= in_ch.data_byte;
      end else if (pos == POS_ATTR) begin
        attr_byte <= in_ch.data_byte;
      end else if (pos == POS_CLUS_HI_0) begin
        cluster_high[7:0] <= in_ch.data_byte;
      end else if (pos == POS_CLUS_HI_1) begin
        cluster_high[15:8] <= in_ch.data_byte;
      end else if (pos == POS_CLUS_LO_0) begin
        cluster_low[7:0] <= in_ch.data_byte;
      end else if (pos == POS_CLUS_LO_1) begin
        cluster_low[15:8] <= in_ch.data_byte;
      end else if (pos >= POS_SIZE_0) begin
        size_bytes[pos[1:0]] <= in_ch.data_byte;
      end
    end
  end

  // The last byte completes the entry; its size byte goes straight into the record.
  assign push             = accept && (pos == POS_LAST);
  assign push_rec.name    = name_bytes;
  assign push_rec.attr    = attr_byte;
  assign push_rec.cluster = {cluster_high, cluster_low};
  assign push_rec.size    = {in_ch.data_byte, size_bytes[2], size_bytes[1], size_bytes[0]};

  // A completed entry always leaves the position at the start of the next one.
  a_wrap_after_push: assert property (@(posedge clk) disable iff (rst)
    push |=> (entry_position == '0))
    else $error("position did not wrap after a completed entry");

endmodule

/* rtl/fdem_queue.sv */
// Short queue of captured entries between the capture and the decode side.
module fdem_queue
  import fdem_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  entry_rec_t push_rec,
  input  logic       pop,
  output logic       full,
  output logic       head_valid,
  output entry_rec_t head_rec
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_rec_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_rec   = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // The fill count never passes the depth, and nothing is taken from an empty queue.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill count exceeds depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("entry taken from an empty queue");

endmodule

/* rtl/fdem_back.sv */
// Decode side: classifies an entry, forms its name and compares it with the target.
module fdem_back
  import fdem_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  entry_rec_t head_rec,
  input  target_t    target,
  output logic       pop,
  fdem_out_if.source out_ch
);

  kind_t                      kind;
  logic [3:0]                 base_len;
  logic [3:0]                 ext_len;
  logic [3:0]                 formed_len;
  logic [3:0]                 ext_idx;
  logic                       stopped;
  logic                       hit;
  logic                       has_ext;
  logic [FORMED_MAX-1:0][7:0] raw;
  logic [FORMED_MAX-1:0][7:0] formed;
  logic [FORMED_MAX-1:0]      char_ok;
  logic                       match;
  logic                       out_valid;

  // Folds a-z to upper case and leaves every other byte alone.
  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

  // Entry kind, tested from the first byte down to the attribute bits.
  always_comb begin
    priority if (head_rec.name[0] == CHAR_NUL) begin
      kind = KIND_END;
    end else if (head_rec.name[0] == MARK_DELETED) begin
      kind = KIND_DELETED;
    end else if (head_rec.attr == ATTR_LONG_NAME) begin
      kind = KIND_LONG_NAME;
    end else if ((head_rec.attr & ATTR_VOLUME) != '0) begin
      kind = KIND_VOLUME;
    end else if ((head_rec.attr & ATTR_DIRECTORY) != '0) begin
      kind = KIND_DIRECTORY;
    end else begin
      kind = KIND_FILE;
    end
  end

  // Base and extension lengths; a zero byte in the base also drops the extension.
  always_comb begin
    base_len = 4'(BASE_BYTES);
    stopped  = 1'b0;
    hit      = 1'b0;
    for (int i = 0; i < BASE_BYTES; i++) begin
      if (!hit) begin
        if (head_rec.name[i] == CHAR_NUL) begin
          base_len = 4'(i);
          stopped  = 1'b1;
          hit      = 1'b1;
        end else if (head_rec.name[i] == CHAR_SPACE) begin
          base_len = 4'(i);
          hit      = 1'b1;
        end
      end
    end
    ext_len = 4'(EXT_BYTES);
    hit     = 1'b0;
    for (int i = 0; i < EXT_BYTES; i++) begin
      if (!hit && (head_rec.name[BASE_BYTES + i] == CHAR_NUL ||
                   head_rec.name[BASE_BYTES + i] == CHAR_SPACE)) begin
        ext_len = 4'(i);
        hit     = 1'b1;
      end
    end
    has_ext    = !stopped && (head_rec.name[BASE_BYTES] != CHAR_SPACE);
    formed_len = has_ext ? base_len + 4'd1 + ext_len : base_len;
  end

  // Formed BASE.EXT name, one character per place, and its compare with the target.
  always_comb begin
    raw = {CHAR_SPACE, head_rec.name};
    for (int i = 0; i < FORMED_MAX; i++) begin
      ext_idx = 4'(i) - base_len - 4'd1;
      if (4'(i) < base_len) begin
        formed[i] = raw[i];
      end else if (4'(i) == base_len) begin
        formed[i] = CHAR_DOT;
      end else if (ext_idx < 4'(EXT_BYTES)) begin
        formed[i] = raw[4'(BASE_BYTES) + ext_idx];
      end else begin
        formed[i] = CHAR_SPACE;
      end
      char_ok[i] = (4'(i) >= formed_len) ||
                   (fold_upper(formed[i]) == fold_upper(target.chars[i]));
    end
    match = (kind == KIND_FILE) && (target.len <= 4'(FORMED_MAX)) &&
            (formed_len == target.len) && (&char_ok);
  end

  // Output register: a new entry is taken whenever the old result is gone or leaving.
  assign pop = head_valid && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ch.ready) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_ch.entry_kind    <= kind;
      out_ch.name_matches  <= match;
      out_ch.name_blank    <= (formed_len == '0);
      out_ch.empty_file    <= (head_rec.size == '0) || (head_rec.cluster < 32'd2);
      out_ch.first_cluster <= head_rec.cluster;
      out_ch.entry_size    <= head_rec.size;
      out_ch.attributes    <= head_rec.attr;
    end
  end

  assign out_ch.valid = out_valid;

  // A match is only ever reported for a file entry.
  a_match_is_file: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ch.name_matches) |-> (out_ch.entry_kind == KIND_FILE))
    else $error("name match reported for an entry that is not a file");

endmodule

/* rtl/fat_directory_entry_matcher_top.sv */
// Top level of the FAT directory entry matcher: configuration registers and the datapath.
//
// The block takes one directory byte per clock cycle and emits one result per 32-byte
// entry, so it keeps up with a byte stream that never pauses as long as results are
// taken as they come. The edge that accepts the last byte of an entry writes it into a
// short queue; the decode side then forms the BASE.EXT name, compares it with the
// target and loads the output register once that register is free or being read. A
// sector start restarts the entry and drops any partial one. Input is held off only
// while the queue is full, which takes a stalled result channel. The user must set the
// target name through the register port while no entry is in flight; the block does
// not enforce this. Registers sit at byte addresses 0, 8 and 16.
module fat_directory_entry_matcher_top
  import fdem_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
  input  logic        clk,
  input  logic        rst,
  fdem_in_if.sink     in_ch,
  fdem_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] target_first_eight;
  logic [31:0] target_last_four;
  logic [3:0]  target_length;
  reg_index_t  reg_index;
  logic        cfg_write;
  target_t     target;
  logic        push;
  entry_rec_t  push_rec;
  logic        pop;
  logic        queue_full;
  logic        head_valid;
  entry_rec_t  head_rec;

  // Register port: eight-byte register slots, writes land in the access cycle.
  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[4:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_first_eight <= '0;
      target_last_four   <= '0;
      target_length      <= '0;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_FIRST_EIGHT: target_first_eight <= pwdata;
        REG_LAST_FOUR:   target_last_four   <= pwdata[31:0];
        REG_LENGTH:      target_length      <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_index)
      REG_FIRST_EIGHT: prdata = target_first_eight;
      REG_LAST_FOUR:   prdata = {32'd0, target_last_four};
      REG_LENGTH:      prdata = {60'd0, target_length};
      default:         prdata = '0;
    endcase
  end

  assign target.chars = {target_last_four, target_first_eight};
  assign target.len   = target_length;

  fdem_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .queue_full (queue_full),
    .push       (push),
    .push_rec   (push_rec)
  );

  fdem_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  fdem_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .target     (target),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

/* tb/tb_fat_directory_entry_matcher_top.sv */
`timescale 1ns / 100ps
// Testbench that streams FAT directory bytes into the entry matcher and checks every decoded entry.
module tb_fat_directory_entry_matcher_top;
  import fdem_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int REPORT_LIMIT  = 10;

  typedef logic [NAME_BYTES-1:0][7:0]  short_name_t;
  typedef logic [FORMED_MAX-1:0][7:0]  formed_name_t;
  typedef logic [ENTRY_BYTES-1:0][7:0] entry_bytes_t;

  typedef enum {START_RANDOM, START_ALWAYS, START_NEVER} start_mode_t;

  // One decoded directory entry as the block should report it.
  typedef struct {
    kind_t       kind;
    logic        name_hit;
    logic        blank;
    logic        empty;
    logic [31:0] cluster;
    logic [31:0] size;
    logic [7:0]  attr;
  } entry_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  fdem_in_if  in_ch();
  fdem_out_if out_ch();

  fat_directory_entry_matcher_top DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Target name as last written to the registers.
  logic [63:0] tgt_first_eight = '0;
  logic [31:0] tgt_last_four   = '0;
  logic [3:0]  tgt_length      = '0;

  // Capture state of the entry currently being assembled.
  logic [4:0]  entry_pos  = '0;
  short_name_t name_bytes = '0;
  logic [7:0]  attr_byte  = '0;
  logic [15:0] clus_hi    = '0;
  logic [15:0] clus_lo    = '0;
  logic [31:0] size_word  = '0;

  entry_result_t expected_entries[$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_left      = 0;
  bit          hold_request   = 1'b0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Only a-z fold to upper case; every other byte compares as is.
  function automatic logic [7:0] upcase(logic [7:0] c);
    if (c >= "a" && c <= "z") begin
      return c - 8'h20;
    end
    return c;
  endfunction

  // Builds BASE.EXT from the 11 raw name bytes and returns its length.
  function automatic int form_short_name(short_name_t nm, output formed_name_t formed);
    int i;
    int len;
    bit stopped;
    bit done;
    len = 0;
    stopped = 1'b0;
    done = 1'b0;
    formed = '0;
    for (i = 0; i < BASE_BYTES; i++) begin
      if (!done) begin
        if (nm[i] == CHAR_NUL) begin
          stopped = 1'b1;
          done = 1'b1;
        end else if (nm[i] == CHAR_SPACE) begin
          done = 1'b1;
        end else begin
          formed[len] = nm[i];
          len++;
        end
      end
    end
    // A zero byte in the base ends the name, but one at byte 8 still gets the dot.
    if (!stopped && nm[BASE_BYTES] != CHAR_SPACE) begin
      formed[len] = CHAR_DOT;
      len++;
      done = 1'b0;
      for (i = BASE_BYTES; i < NAME_BYTES; i++) begin
        if (!done) begin
          if (nm[i] == CHAR_NUL || nm[i] == CHAR_SPACE) begin
            done = 1'b1;
          end else begin
            formed[len] = nm[i];
            len++;
          end
        end
      end
    end
    return len;
  endfunction

  function automatic logic [7:0] target_char(int i);
    if (i < 8) begin
      return tgt_first_eight[8*i +: 8];
    end
    return tgt_last_four[8*(i-8) +: 8];
  endfunction

  // Follows one accepted byte and queues the decoded entry after byte 31.
  task automatic track_directory_byte(logic [7:0] b, logic ss);
    logic [4:0]    pos;
    formed_name_t  formed;
    int            len;
    int            i;
    entry_result_t res;
    logic [31:0]   cluster;
    if (ss) begin
      entry_pos = '0;
    end
    pos = entry_pos;
    if (pos < NAME_BYTES) begin
      name_bytes[pos] = b;
    end else if (pos == POS_ATTR) begin
      attr_byte = b;
    end else if (pos == POS_CLUS_HI_0) begin
      clus_hi[7:0] = b;
    end else if (pos == POS_CLUS_HI_1) begin
      clus_hi[15:8] = b;
    end else if (pos == POS_CLUS_LO_0) begin
      clus_lo[7:0] = b;
    end else if (pos == POS_CLUS_LO_1) begin
      clus_lo[15:8] = b;
    end else if (pos >= POS_SIZE_0) begin
      size_word[8*(pos-POS_SIZE_0) +: 8] = b;
    end
    entry_pos = pos + 5'd1;
    if (pos != POS_LAST) begin
      return;
    end

    if (name_bytes[0] == CHAR_NUL) begin
      res.kind = KIND_END;
    end else if (name_bytes[0] == MARK_DELETED) begin
      res.kind = KIND_DELETED;
    end else if (attr_byte == ATTR_LONG_NAME) begin
      res.kind = KIND_LONG_NAME;
    end else if ((attr_byte & ATTR_VOLUME) != 0) begin
      res.kind = KIND_VOLUME;
    end else if ((attr_byte & ATTR_DIRECTORY) != 0) begin
      res.kind = KIND_DIRECTORY;
    end else begin
      res.kind = KIND_FILE;
    end

    len = form_short_name(name_bytes, formed);
    res.name_hit = (res.kind == KIND_FILE && tgt_length <= FORMED_MAX && len == tgt_length);
    for (i = 0; i < len; i++) begin
      if (upcase(formed[i]) != upcase(target_char(i))) begin
        res.name_hit = 1'b0;
      end
    end
    cluster = {clus_hi, clus_lo};
    res.blank = (len == 0);
    res.empty = (size_word == 0 || cluster < 2);
    res.cluster = cluster;
    res.size = size_word;
    res.attr = attr_byte;
    expected_entries.push_back(res);
  endtask

  task automatic report_mismatch(string what, logic [31:0] exp_val, logic [31:0] act_val);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, what, exp_val,
               act_val);
    end
  endtask

  task automatic compare_field(string what, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      report_mismatch(what, exp_val, act_val);
    end
  endtask

  // Result receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Each accepted result is checked against the oldest queued entry.
  always @(posedge clk) begin
    entry_result_t exp_res;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_entries.size() == 0) begin
        report_mismatch("unexpected result, kind", 0, out_ch.entry_kind);
      end else begin
        exp_res = expected_entries.pop_front();
        compare_field("entry_kind", exp_res.kind, out_ch.entry_kind);
        compare_field("name_matches", exp_res.name_hit, out_ch.name_matches);
        compare_field("name_blank", exp_res.blank, out_ch.name_blank);
        compare_field("empty_file", exp_res.empty, out_ch.empty_file);
        compare_field("first_cluster", exp_res.cluster, out_ch.first_cluster);
        compare_field("entry_size", exp_res.size, out_ch.entry_size);
        compare_field("attributes", exp_res.attr, out_ch.attributes);
      end
    end
  end

  // Offers one byte, with random idle cycles first, and waits until it is taken.
  task automatic send_byte(logic [7:0] b, logic ss);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.sector_start <= ss;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) begin
      @(posedge clk);
    end
    track_directory_byte(b, ss);
  endtask

  // A misaligned stream always gets a sector start so the entry lines up.
  task automatic send_entry(entry_bytes_t e, start_mode_t mode);
    logic ss;
    int   i;
    ss = (mode == START_ALWAYS) || (entry_pos != 0) ||
         (mode == START_RANDOM && $urandom_range(1) == 1);
    for (i = 0; i < ENTRY_BYTES; i++) begin
      send_byte(e[i], (i == 0) ? ss : 1'b0);
    end
  endtask

  function automatic entry_bytes_t build_entry(short_name_t nm, logic [7:0] attr,
                                               logic [31:0] cluster, logic [31:0] size);
    entry_bytes_t e;
    int i;
    for (i = 0; i < ENTRY_BYTES; i++) begin
      e[i] = 8'($urandom);
    end
    for (i = 0; i < NAME_BYTES; i++) begin
      e[i] = nm[i];
    end
    e[POS_ATTR]      = attr;
    e[POS_CLUS_HI_0] = cluster[23:16];
    e[POS_CLUS_HI_1] = cluster[31:24];
    e[POS_CLUS_LO_0] = cluster[7:0];
    e[POS_CLUS_LO_1] = cluster[15:8];
    for (i = 0; i < 4; i++) begin
      e[POS_SIZE_0 + i] = size[8*i +: 8];
    end
    return e;
  endfunction

  // Raw 11-byte name from text, padded with spaces.
  function automatic short_name_t text_name(string s);
    short_name_t nm;
    int i;
    for (i = 0; i < NAME_BYTES; i++) begin
      nm[i] = (i < s.len()) ? s[i] : CHAR_SPACE;
    end
    return nm;
  endfunction

  function automatic formed_name_t pack_chars(string s);
    formed_name_t p;
    int i;
    p = '0;
    for (i = 0; i < s.len() && i < FORMED_MAX; i++) begin
      p[i] = s[i];
    end
    return p;
  endfunction

  function automatic short_name_t flip_case(short_name_t nm);
    int i;
    for (i = 0; i < NAME_BYTES; i++) begin
      if (((nm[i] >= "A" && nm[i] <= "Z") || (nm[i] >= "a" && nm[i] <= "z")) &&
          $urandom_range(1) == 1) begin
        nm[i] = nm[i] ^ 8'h20;
      end
    end
    return nm;
  endfunction

  function automatic logic [7:0] random_name_char();
    case ($urandom_range(3))
      0: return 8'("A" + $urandom_range(25));
      1: return 8'("a" + $urandom_range(25));
      2: return 8'("0" + $urandom_range(9));
      default: return 8'($urandom_range(8'hFF, 8'h21));
    endcase
  endfunction

  // Mostly well-formed names; now and then a zero byte or any byte at all.
  function automatic short_name_t random_short_name();
    short_name_t nm;
    int base_len;
    int ext_len;
    int i;
    nm = {NAME_BYTES{CHAR_SPACE}};
    base_len = $urandom_range(BASE_BYTES);
    ext_len = $urandom_range(EXT_BYTES);
    for (i = 0; i < base_len; i++) begin
      nm[i] = random_name_char();
    end
    for (i = 0; i < ext_len; i++) begin
      nm[BASE_BYTES + i] = random_name_char();
    end
    if ($urandom_range(9) == 0) begin
      nm[$urandom_range(NAME_BYTES-1)] = CHAR_NUL;
    end
    if ($urandom_range(9) == 0) begin
      nm[$urandom_range(NAME_BYTES-1)] = 8'($urandom);
    end
    return nm;
  endfunction

  function automatic entry_bytes_t random_entry(short_name_t target_nm);
    short_name_t nm;
    logic [7:0]  attr;
    logic [31:0] cluster;
    logic [31:0] size;
    nm = ($urandom_range(2) == 0) ? random_short_name() : flip_case(target_nm);
    case ($urandom_range(11))
      0: nm[0] = CHAR_NUL;
      1: nm[0] = MARK_DELETED;
      default: ;
    endcase
    case ($urandom_range(7))
      0: attr = 8'h20;
      1: attr = 8'h00;
      2: attr = 8'($urandom) & ~(ATTR_VOLUME | ATTR_DIRECTORY);
      3: attr = ATTR_LONG_NAME;
      4: attr = 8'($urandom) | ATTR_VOLUME;
      5: attr = (8'($urandom) & ~ATTR_VOLUME) | ATTR_DIRECTORY;
      default: attr = 8'($urandom);
    endcase
    case ($urandom_range(3))
      0: cluster = $urandom_range(2);
      1: cluster = {16'($urandom), 16'h0000};
      default: cluster = $urandom;
    endcase
    size = ($urandom_range(4) == 0) ? 32'h0 : $urandom;
    return build_entry(nm, attr, cluster, size);
  endfunction

  // Lowers the byte channel and waits until every queued entry has come out.
  task automatic wait_idle();
    int n;
    n = 0;
    in_ch.valid <= 1'b0;
    while (expected_entries.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready. Select stays up for the next write.
  task automatic write_register(reg_index_t idx, logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) begin
      @(posedge clk);
    end
    case (idx)
      REG_FIRST_EIGHT: tgt_first_eight = value;
      REG_LAST_FOUR:   tgt_last_four = value[31:0];
      REG_LENGTH:      tgt_length = value[3:0];
      default: ;
    endcase
  endtask

  task automatic set_target(logic [63:0] first_eight, logic [31:0] last_four,
                            logic [3:0] name_len);
    wait_idle();
    write_register(REG_FIRST_EIGHT, first_eight);
    write_register(REG_LAST_FOUR, {32'h0, last_four});
    write_register(REG_LENGTH, {60'h0, name_len});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_target_text(string s, logic [3:0] name_len);
    formed_name_t p;
    p = pack_chars(s);
    set_target(p[7:0], p[11:8], name_len);
  endtask

  // Every entry kind, kind precedence, and the empty-file boundaries.
  task automatic test_entry_kinds();
    short_name_t nm;
    set_target_text("readme.txt", 4'd10);
    send_entry(build_entry(text_name("ReAdMe  TxT"), 8'h20, 32'd5, 32'd100), START_ALWAYS);
    nm = text_name("END     BIN");
    nm[0] = CHAR_NUL;
    send_entry(build_entry(nm, 8'h20, 32'd7, 32'd1), START_RANDOM);
    nm = text_name("README  TXT");
    nm[0] = MARK_DELETED;
    send_entry(build_entry(nm, 8'h20, 32'd1, 32'd9), START_RANDOM);
    send_entry(build_entry(text_name("README  TXT"), ATTR_LONG_NAME, 32'd2, 32'd0),
               START_RANDOM);
    send_entry(build_entry(text_name("DISKVOL"), ATTR_VOLUME, 32'd0, 32'd0), START_RANDOM);
    send_entry(build_entry(text_name("README  TXT"), ATTR_DIRECTORY, 32'h0001_0000, 32'd3),
               START_RANDOM);
    // Volume wins over directory when both bits are set.
    send_entry(build_entry(text_name("BOTH"), ATTR_VOLUME | ATTR_DIRECTORY, 32'd2, 32'd1),
               START_RANDOM);
    send_entry('1, START_RANDOM);
    send_entry('0, START_RANDOM);
  endtask

  // Zero bytes inside the name, sector start mid entry, and position wrap.
  task automatic test_name_forms();
    short_name_t nm;
    int i;
    set_target_text("ABC.", 4'd4);
    nm = text_name("ABC");
    nm[8] = CHAR_NUL;
    send_entry(build_entry(nm, 8'h00, 32'd2, 32'd1), START_ALWAYS);
    nm = text_name("ABCD    TXT");
    nm[2] = CHAR_NUL;
    send_entry(build_entry(nm, 8'h00, 32'd3, 32'd1), START_RANDOM);
    nm = text_name("ABC     XYZ");
    nm[9] = CHAR_NUL;
    send_entry(build_entry(nm, 8'h00, 32'd3, 32'd1), START_RANDOM);
    // A partial entry is dropped when a new sector starts.
    send_byte(8'h41, 1'b1);
    for (i = 1; i < 17; i++) begin
      send_byte(8'($urandom), 1'b0);
    end
    send_entry(build_entry(text_name("abc"), 8'h00, 32'd4, 32'd4), START_ALWAYS);
    // Back-to-back entries without a sector start.
    send_entry(build_entry(text_name("ABCDEFGH"), 8'h01, 32'd5, 32'd5), START_NEVER);
    send_entry(build_entry(text_name("aBc"), 8'h00, 32'd6, 32'd6), START_NEVER);
  endtask

  // Target length extremes, a zero byte in the target, and case folding limits.
  task automatic test_target_limits();
    formed_name_t p;
    set_target_text("ABCDEFGH.XYZ", 4'd13);
    send_entry(build_entry(text_name("ABCDEFGHXYZ"), 8'h00, 32'd2, 32'd1), START_ALWAYS);
    set_target_text("ABCDEFGH.XYZ", 4'd12);
    send_entry(build_entry(text_name("abcdefghxyz"), 8'h00, 32'd2, 32'd1), START_RANDOM);
    set_target('0, '0, 4'd0);
    send_entry(build_entry(text_name(""), 8'h00, 32'd9, 32'd1), START_RANDOM);
    send_entry(build_entry(text_name(" X"), 8'h20, 32'd9, 32'd1), START_RANDOM);
    send_entry(build_entry(text_name(""), ATTR_DIRECTORY, 32'd9, 32'd1), START_RANDOM);
    send_entry(build_entry(text_name("        X"), 8'h00, 32'd9, 32'd1), START_RANDOM);
    set_target('1, '1, 4'd12);
    send_entry(build_entry('1, 8'h00, '1, '1), START_RANDOM);
    set_target('1, '1, 4'd15);
    send_entry(build_entry('1, 8'h00, '1, '1), START_RANDOM);
    p = pack_chars("AXC");
    p[1] = CHAR_NUL;
    set_target(p[7:0], p[11:8], 4'd3);
    send_entry(build_entry(text_name("AXC"), 8'h00, 32'd2, 32'd1), START_RANDOM);
    set_target_text("Z@[", 4'd3);
    send_entry(build_entry(text_name("z@["), 8'h00, 32'd2, 32'd1), START_RANDOM);
    send_entry(build_entry(text_name("z`{"), 8'h00, 32'd2, 32'd1), START_RANDOM);
  endtask

  // Random target, then mostly well-formed entries with partial entries and noise mixed in.
  task automatic test_random_traffic(int idle_pct, int stall_pct, int entry_count);
    short_name_t  target_nm;
    formed_name_t formed;
    int           len;
    int           count;
    int           pick;
    int           i;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target_nm = random_short_name();
    len = form_short_name(target_nm, formed);
    for (i = len; i < FORMED_MAX; i++) begin
      formed[i] = 8'($urandom);
    end
    case ($urandom_range(9))
      0: set_target({$urandom, $urandom}, $urandom, 4'($urandom));
      1: set_target(formed[7:0], formed[11:8], 4'($urandom_range(15, 13)));
      default: set_target(formed[7:0] ^ {8{8'h20 & 8'($urandom)}}, formed[11:8], 4'(len));
    endcase
    send_entry(random_entry(target_nm), START_ALWAYS);
    count = 1;
    while (count < entry_count) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_entry(random_entry(target_nm), START_RANDOM);
        count++;
      end else if (pick < 87) begin
        send_byte(8'($urandom), 1'b1);
        repeat ($urandom_range(30)) send_byte(8'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(40, 1)) send_byte(8'($urandom), $urandom_range(15) == 0);
      end
    end
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_target_text("HOLD.BIN", 4'd8);
    hold_request = 1'b1;
    repeat (4) send_entry(random_entry(text_name("HOLD    BIN")), START_RANDOM);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.sector_start = 1'b0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_entry_kinds();
    test_name_forms();
    test_target_limits();
    test_random_traffic(0, 0, 1);
    test_random_traffic(82, 0, 1);
    test_random_traffic(0, 82, 1);
    test_random_traffic(19, 19, 1);
    test_output_hold();

    wait_idle();
    if (mismatch_count == 0 && expected_entries.size() == 0) begin
      $display("fat_directory_entry_matcher_top test passed");
    end else begin
      $display("fat_directory_entry_matcher_top test failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("fat_directory_entry_matcher_top test failed");
    $finish;
  end

endmodule

/* fat_directory_entry_matcher_top.f */
rtl/fdem_pkg.sv
rtl/fdem_in_if.sv
rtl/fdem_out_if.sv
rtl/fdem_front.sv
rtl/fdem_queue.sv
rtl/fdem_back.sv
rtl/fat_directory_entry_matcher_top.sv
tb/tb_fat_directory_entry_matcher_top.sv
